[rtl/ppr_pkg.sv]
`timescale 1ns / 1ps
package ppr_pkg;

  localparam int COEF_W = 48;
  localparam int COEF_N = 8;
  localparam int IDX_W = 3;
  localparam int ACC_W = 62;
  // quotient bits per lane; the top bit flags a quotient of 4096 or more
  localparam int Q_BITS = 13;
  localparam int FRONT_STAGES = 3;
  localparam int DEST_WIDTH_DEF = 1024;
  localparam int DEST_HEIGHT_DEF = 512;
  localparam logic [ACC_W-1:0] ONE_Q28 = ACC_W'(64'd1 << 28);

  typedef enum logic [IDX_W-1:0] {
    REG_XX = 3'd0,
    REG_XY = 3'd1,
    REG_XT = 3'd2,
    REG_YX = 3'd3,
    REG_YY = 3'd4,
    REG_YT = 3'd5,
    REG_WX = 3'd6,
    REG_WY = 3'd7
  } reg_idx_t;

  // division word handed from cell to cell
  typedef struct packed {
    logic [ACC_W-1:0]  rem_x;
    logic [ACC_W-1:0]  rem_y;
    logic [Q_BITS-1:0] q_x;
    logic [Q_BITS-1:0] q_y;
    logic [ACC_W-1:0]  dvs;
  } div_t;

  // sign and zero status of one word
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic d_zero;
  } flags_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

endpackage

[rtl/ppr_front.sv]
`timescale 1ns / 1ps
module ppr_front
  import ppr_pkg::*;
(
  input  logic                     clk,
  input  logic [FRONT_STAGES-1:0]  en,
  input  logic [11:0]              src_x,
  input  logic [11:0]              src_y,
  input  logic [COEF_W-1:0]        coef [COEF_N],
  output div_t                     div_out,
  output flags_t                   flags_out
);

  logic signed [COEF_W+12:0] prod [6];
  logic signed [ACC_W-1:0]   nx;
  logic signed [ACC_W-1:0]   ny;
  logic signed [ACC_W-1:0]   dd;
  logic signed [12:0]        xs;
  logic signed [12:0]        ys;

  assign xs = $signed({1'b0, src_x});
  assign ys = $signed({1'b0, src_y});

  // stage 0: six coefficient products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod[0] <= $signed(coef[REG_XX]) * xs;
      prod[1] <= $signed(coef[REG_XY]) * ys;
      prod[2] <= $signed(coef[REG_YX]) * xs;
      prod[3] <= $signed(coef[REG_YY]) * ys;
      prod[4] <= $signed(coef[REG_WX]) * xs;
      prod[5] <= $signed(coef[REG_WY]) * ys;
    end
  end

  // stage 1: numerators and denominator
  always_ff @(posedge clk) begin
    if (en[1]) begin
      nx <= ACC_W'(prod[0]) + ACC_W'(prod[1]) + ACC_W'($signed(coef[REG_XT]));
      ny <= ACC_W'(prod[2]) + ACC_W'(prod[3]) + ACC_W'($signed(coef[REG_YT]));
      dd <= ACC_W'(prod[4]) + ACC_W'(prod[5]) + $signed(ONE_Q28);
    end
  end

  // stage 2: magnitudes and signs
  always_ff @(posedge clk) begin
    if (en[2]) begin
      div_out.rem_x    <= nx[ACC_W-1] ? ACC_W'(-nx) : nx;
      div_out.rem_y    <= ny[ACC_W-1] ? ACC_W'(-ny) : ny;
      div_out.dvs      <= dd[ACC_W-1] ? ACC_W'(-dd) : dd;
      div_out.q_x      <= '0;
      div_out.q_y      <= '0;
      flags_out.neg_x  <= nx[ACC_W-1] ^ dd[ACC_W-1];
      flags_out.neg_y  <= ny[ACC_W-1] ^ dd[ACC_W-1];
      flags_out.d_zero <= (dd == '0);
    end
  end

endmodule

[rtl/ppr_cell.sv]
`timescale 1ns / 1ps
module ppr_cell
  import ppr_pkg::*;
#(
  parameter int K = 0
) (
  input  logic clk,
  input  logic en,
  input  div_t din,
  output div_t dout
);

  localparam int SW = ACC_W + Q_BITS;

  logic [SW-1:0] shifted;
  logic          ge_x;
  logic          ge_y;
  div_t          dnext;

  // one restoring quotient bit per lane
  always_comb begin
    shifted = {{Q_BITS{1'b0}}, din.dvs} << K;
    ge_x = {{Q_BITS{1'b0}}, din.rem_x} >= shifted;
    ge_y = {{Q_BITS{1'b0}}, din.rem_y} >= shifted;
    dnext = din;
    if (ge_x) dnext.rem_x = din.rem_x - shifted[ACC_W-1:0];
    if (ge_y) dnext.rem_y = din.rem_y - shifted[ACC_W-1:0];
    dnext.q_x[K] = ge_x;
    dnext.q_y[K] = ge_y;
  end

  always_ff @(posedge clk) begin
    if (en) dout <= dnext;
  end

endmodule

[rtl/perspective_pixel_remap.sv]
`timescale 1ns / 1ps
// Perspective pixel remap: forward homography warp of a pixel stream.
// Input channel: src_x, src_y and the three color bytes, moved with
// in_valid / in_stall; a word is taken when in_valid is high and in_stall low.
// Output channel: one pixel write (dest_x, dest_y, colors) on out_valid /
// out_stall. Pixels that land outside the frame or meet a zero denominator
// give no output word.
// Coefficients are written through wr_en / wr_index / wr_data while idle.
// The pipeline is three front stages (products, sums, magnitudes),
// one divider cell per quotient bit (13 cells, the chain sets the depth),
// then the output register. Throughput is one pixel per clock while out_stall is low.
// Each stage moves on when the one after it is empty or moving, so bubbles
// close up; a stalled output holds its word and the chain keeps filling
// behind it until it is full, then in_stall rises.
// Reset (rst, synchronous) empties the pipeline and loads the identity
// transform.
module perspective_pixel_remap
  import ppr_pkg::*;
#(
  parameter int DEST_WIDTH  = DEST_WIDTH_DEF,
  parameter int DEST_HEIGHT = DEST_HEIGHT_DEF,
  localparam int XW = (DEST_WIDTH > 1) ? $clog2(DEST_WIDTH) : 1,
  localparam int YW = (DEST_HEIGHT > 1) ? $clog2(DEST_HEIGHT) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [COEF_W-1:0] wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [11:0]       src_x,
  input  logic [11:0]       src_y,
  input  logic [7:0]        in_blue,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_red,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [XW-1:0]     dest_x,
  output logic [YW-1:0]     dest_y,
  output logic [7:0]        out_blue,
  output logic [7:0]        out_green,
  output logic [7:0]        out_red
);

  localparam int NS = FRONT_STAGES + Q_BITS;

  logic [COEF_W-1:0] coef [COEF_N];
  logic [NS-1:0]     v;
  logic [NS:0]       en;
  color_t            col [NS];
  flags_t            flg [FRONT_STAGES:NS-1];
  flags_t            front_flags;
  div_t              dv [Q_BITS+1];
  logic              x_ok;
  logic              y_ok;
  logic              keep;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COEF_N; i++) begin
        coef[i] <= (i == int'(REG_XX) || i == int'(REG_YY)) ? COEF_W'(ONE_Q28) : '0;
      end
    end else if (wr_en) begin
      coef[wr_index] <= wr_data;
    end
  end

  // stage enables: a stage loads when empty or when the next one loads
  always_comb begin
    en[NS] = !out_valid || !out_stall;
    for (int i = NS - 1; i >= 0; i--) en[i] = !v[i] || en[i+1];
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i < NS; i++) if (en[i]) v[i] <= v[i-1];
    end
  end

  // color and flag side pipe
  always_ff @(posedge clk) begin
    if (en[0]) col[0] <= '{blue: in_blue, green: in_green, red: in_red};
    for (int i = 1; i < NS; i++) if (en[i]) col[i] <= col[i-1];
    if (en[FRONT_STAGES]) flg[FRONT_STAGES] <= front_flags;
    for (int i = FRONT_STAGES + 1; i < NS; i++) if (en[i]) flg[i] <= flg[i-1];
  end

  ppr_front u_front (
    .clk       (clk),
    .en        (en[FRONT_STAGES-1:0]),
    .src_x     (src_x),
    .src_y     (src_y),
    .coef      (coef),
    .div_out   (dv[0]),
    .flags_out (front_flags)
  );

  // divider chain, most significant quotient bit first
  for (genvar c = 0; c < Q_BITS; c++) begin : g_cell
    ppr_cell #(.K(Q_BITS - 1 - c)) u_cell (
      .clk  (clk),
      .en   (en[FRONT_STAGES+c]),
      .din  (dv[c]),
      .dout (dv[c+1])
    );
  end

  // frame test on the finished quotients
  always_comb begin
    x_ok = !dv[Q_BITS].q_x[Q_BITS-1] &&
           (flg[NS-1].neg_x ? (dv[Q_BITS].q_x == '0)
                            : (dv[Q_BITS].q_x < Q_BITS'(DEST_WIDTH)));
    y_ok = !dv[Q_BITS].q_y[Q_BITS-1] &&
           (flg[NS-1].neg_y ? (dv[Q_BITS].q_y == '0)
                            : (dv[Q_BITS].q_y < Q_BITS'(DEST_HEIGHT)));
    keep = x_ok && y_ok && !flg[NS-1].d_zero;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en[NS]) begin
      out_valid <= v[NS-1] && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS]) begin
      dest_x    <= dv[Q_BITS].q_x[XW-1:0];
      dest_y    <= dv[Q_BITS].q_y[YW-1:0];
      out_blue  <= col[NS-1].blue;
      out_green <= col[NS-1].green;
      out_red   <= col[NS-1].red;
    end
  end

endmodule

[rtl/ppr_checker.sv]
`timescale 1ns / 1ps
module ppr_checker
  import ppr_pkg::*;
#(
  parameter int DEST_WIDTH  = DEST_WIDTH_DEF,
  parameter int DEST_HEIGHT = DEST_HEIGHT_DEF,
  localparam int XW = (DEST_WIDTH > 1) ? $clog2(DEST_WIDTH) : 1,
  localparam int YW = (DEST_HEIGHT > 1) ? $clog2(DEST_HEIGHT) : 1
) (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_stall,
  input logic [XW-1:0] dest_x,
  input logic [YW-1:0] dest_y
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dest_x) && $stable(dest_y))
    else $error("stalled output word changed");

  // writes stay inside the frame
  a_x_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, dest_x} < (XW+1)'(DEST_WIDTH)))
    else $error("dest_x outside frame");

  a_y_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, dest_y} < (YW+1)'(DEST_HEIGHT)))
    else $error("dest_y outside frame");

  // reset leaves the output empty
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind perspective_pixel_remap ppr_checker #(
  .DEST_WIDTH  (DEST_WIDTH),
  .DEST_HEIGHT (DEST_HEIGHT)
) u_ppr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .dest_x    (dest_x),
  .dest_y    (dest_y)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import ppr_pkg::*;

  localparam int DW = 1024;
  localparam int DH = 512;
  localparam int SETTLE = 40;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint ONE = 64'sd1 << 28;

  typedef struct {
    logic [9:0] dx;
    logic [8:0] dy;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pixel_write_t;

  typedef struct {
    int         cfg_set;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    bit         typed;
    bit         hit;
    logic [9:0] dx;
    logic [8:0] dy;
  } dir_row_t;

  logic clk;
  logic rst;
  logic wr_en;
  logic [IDX_W-1:0] wr_index;
  logic [COEF_W-1:0] wr_data;
  logic in_valid;
  logic in_stall;
  logic [11:0] src_x;
  logic [11:0] src_y;
  logic [7:0] in_blue;
  logic [7:0] in_green;
  logic [7:0] in_red;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [9:0] dest_x;
  logic [8:0] dest_y;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;

  // sideband that travels with each word: typed expectation for table rows
  bit tag_typed;
  bit tag_hit;
  logic [9:0] tag_dx;
  logic [8:0] tag_dy;

  logic signed [COEF_W-1:0] coef [COEF_N];
  pixel_write_t pending_writes[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_cnt = 0;

  perspective_pixel_remap DUT (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .src_x(src_x), .src_y(src_y),
    .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
    .out_valid(out_valid), .out_stall(out_stall), .dest_x(dest_x), .dest_y(dest_y),
    .out_blue(out_blue), .out_green(out_green), .out_red(out_red)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // warp one pixel through the current transform
  function automatic bit warp_pixel(input logic [11:0] x, input logic [11:0] y,
                                    output logic [9:0] dx, output logic [8:0] dy);
    longint xs, ys, nx, ny, d, qx, qy;
    xs = longint'(x);
    ys = longint'(y);
    nx = longint'(coef[REG_XX]) * xs + longint'(coef[REG_XY]) * ys + longint'(coef[REG_XT]);
    ny = longint'(coef[REG_YX]) * xs + longint'(coef[REG_YY]) * ys + longint'(coef[REG_YT]);
    d  = longint'(coef[REG_WX]) * xs + longint'(coef[REG_WY]) * ys + ONE;
    dx = '0;
    dy = '0;
    if (d == 0) return 1'b0;
    qx = nx / d;
    qy = ny / d;
    if (qx < 0 || qx >= DW || qy < 0 || qy >= DH) return 1'b0;
    dx = qx[9:0];
    dy = qy[8:0];
    return 1'b1;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // receiver stall, with long hold-off on request
  always @(posedge clk) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt <= 400;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // accepted input word: queue the expected pixel write
  always @(posedge clk) begin
    pixel_write_t w;
    bit hit;
    if (!rst && in_valid && !in_stall) begin
      if (tag_typed) begin
        hit = tag_hit;
        w.dx = tag_dx;
        w.dy = tag_dy;
      end else begin
        hit = warp_pixel(src_x, src_y, w.dx, w.dy);
      end
      w.b = in_blue;
      w.g = in_green;
      w.r = in_red;
      if (hit) pending_writes = {pending_writes, w};
    end
  end

  // accepted output word: compare with oldest expectation
  always @(posedge clk) begin
    pixel_write_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected pixel write dest_x=%0d dest_y=%0d", dest_x, dest_y);
        errors++;
      end else begin
        w = pending_writes.pop_front();
        if (dest_x !== w.dx) begin
          $error("dest_x expected %0d actual %0d", w.dx, dest_x); errors++;
        end
        if (dest_y !== w.dy) begin
          $error("dest_y expected %0d actual %0d", w.dy, dest_y); errors++;
        end
        if (out_blue !== w.b) begin
          $error("out_blue expected %0d actual %0d", w.b, out_blue); errors++;
        end
        if (out_green !== w.g) begin
          $error("out_green expected %0d actual %0d", w.g, out_green); errors++;
        end
        if (out_red !== w.r) begin
          $error("out_red expected %0d actual %0d", w.r, out_red); errors++;
        end
      end
    end
  end

  task automatic write_coef(input reg_idx_t idx, input logic signed [COEF_W-1:0] v);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= v;
    coef[idx] = v;
    @(posedge clk);
  endtask

  task automatic load_transform(input logic signed [COEF_W-1:0] v [COEF_N]);
    for (int i = 0; i < COEF_N; i++) write_coef(reg_idx_t'(i), v[i]);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every pending write, then let the pipeline empty
  task automatic drain();
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_word(input logic [11:0] x, input logic [11:0] y, input logic [7:0] b,
                           input logic [7:0] g, input logic [7:0] r, input bit typed,
                           input bit hit, input logic [9:0] dx, input logic [8:0] dy);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    src_x <= x;
    src_y <= y;
    in_blue <= b;
    in_green <= g;
    in_red <= r;
    tag_typed <= typed;
    tag_hit <= hit;
    tag_dx <= dx;
    tag_dy <= dy;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  task automatic random_transform(output logic signed [COEF_W-1:0] v [COEF_N]);
    v[REG_XX] = COEF_W'($urandom_range(32'h1000_0000, 32'h0200_0000));
    v[REG_YY] = COEF_W'($urandom_range(32'h1000_0000, 32'h0200_0000));
    v[REG_XY] = $signed(48'(longint'($urandom_range(32'h0400_0000)) - 64'sh0200_0000));
    v[REG_YX] = $signed(48'(longint'($urandom_range(32'h0400_0000)) - 64'sh0200_0000));
    v[REG_XT] = $signed(48'((longint'($urandom_range(1000)) - 500) * ONE + $urandom));
    v[REG_YT] = $signed(48'((longint'($urandom_range(600)) - 300) * ONE + $urandom));
    v[REG_WX] = $signed(48'(longint'($urandom_range(32'h0001_0000)) - 64'sh0000_8000));
    v[REG_WY] = $signed(48'(longint'($urandom_range(32'h0001_0000)) - 64'sh0000_8000));
  endtask

  initial begin
    dir_row_t rows[$];
    logic signed [COEF_W-1:0] cfg [COEF_N];
    int cur_set;

    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    in_valid = 1'b0;
    src_x = '0;
    src_y = '0;
    in_blue = '0;
    in_green = '0;
    in_red = '0;
    tag_typed = 1'b0;
    tag_hit = 1'b0;
    tag_dx = '0;
    tag_dy = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    for (int i = 0; i < COEF_N; i++) coef[i] = '0;
    coef[REG_XX] = COEF_W'(ONE);
    coef[REG_YY] = COEF_W'(ONE);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: identity after reset, then special transforms
    rows = '{
      '{0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 10'd0, 9'd0},
      '{0, 12'd1023, 12'd511, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 10'd1023, 9'd511},
      '{0, 12'd1024, 12'd0, 8'h55, 8'haa, 8'h0f, 1'b1, 1'b0, 10'd0, 9'd0},
      '{0, 12'd0, 12'd512, 8'haa, 8'h55, 8'hf0, 1'b1, 1'b0, 10'd0, 9'd0},
      '{0, 12'd4095, 12'd4095, 8'h01, 8'h80, 8'hfe, 1'b1, 1'b0, 10'd0, 9'd0},
      '{0, 12'd700, 12'd300, 8'h12, 8'h34, 8'h56, 1'b1, 1'b1, 10'd700, 9'd300},
      // half-pixel negative offset, denominator 1 - y
      '{1, 12'd0, 12'd0, 8'h11, 8'h22, 8'h33, 1'b1, 1'b1, 10'd0, 9'd0},
      '{1, 12'd10, 12'd0, 8'h44, 8'h55, 8'h66, 1'b1, 1'b1, 10'd9, 9'd0},
      '{1, 12'd5, 12'd1, 8'h77, 8'h88, 8'h99, 1'b1, 1'b0, 10'd0, 9'd0},
      '{1, 12'd0, 12'd2, 8'haa, 8'hbb, 8'hcc, 1'b0, 1'b0, 10'd0, 9'd0},
      '{1, 12'd4095, 12'd4095, 8'hdd, 8'hee, 8'hff, 1'b0, 1'b0, 10'd0, 9'd0},
      // negative denominator with negated numerators: -5 / -3 and -2 / -3
      '{2, 12'd5, 12'd2, 8'h01, 8'h02, 8'h03, 1'b1, 1'b1, 10'd1, 9'd0},
      '{2, 12'd300, 12'd100, 8'h04, 8'h05, 8'h06, 1'b0, 1'b0, 10'd0, 9'd0},
      '{2, 12'd0, 12'd0, 8'h07, 8'h08, 8'h09, 1'b0, 1'b0, 10'd0, 9'd0},
      // all coefficients at the top of their range
      '{3, 12'd0, 12'd0, 8'hff, 8'h00, 8'hff, 1'b0, 1'b0, 10'd0, 9'd0},
      '{3, 12'd4095, 12'd4095, 8'h00, 8'hff, 8'h00, 1'b0, 1'b0, 10'd0, 9'd0},
      '{3, 12'd1, 12'd4095, 8'h5a, 8'ha5, 8'h3c, 1'b0, 1'b0, 10'd0, 9'd0},
      // all coefficients at the bottom of their range
      '{4, 12'd0, 12'd0, 8'hff, 8'hff, 8'h00, 1'b0, 1'b0, 10'd0, 9'd0},
      '{4, 12'd4095, 12'd4095, 8'h00, 8'h00, 8'hff, 1'b0, 1'b0, 10'd0, 9'd0},
      '{4, 12'd4095, 12'd0, 8'hc3, 8'h3c, 8'h81, 1'b0, 1'b0, 10'd0, 9'd0}
    };
    cur_set = 0;
    foreach (rows[i]) begin
      if (rows[i].cfg_set != cur_set) begin
        in_valid <= 1'b0;
        @(posedge clk);
        drain();
        cur_set = rows[i].cfg_set;
        case (cur_set)
          1: cfg = '{COEF_W'(ONE), '0, COEF_W'(-(ONE / 2)), '0, COEF_W'(ONE), '0, '0,
                     COEF_W'(-ONE)};
          2: cfg = '{COEF_W'(-ONE), '0, '0, '0, COEF_W'(-ONE), '0, '0, COEF_W'(-(2 * ONE))};
          3: cfg = '{default: 48'sh7fff_ffff_ffff};
          default: cfg = '{default: 48'sh8000_0000_0000};
        endcase
        load_transform(cfg);
      end
      send_word(rows[i].x, rows[i].y, rows[i].b, rows[i].g, rows[i].r,
                rows[i].typed, rows[i].hit, rows[i].dx, rows[i].dy);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    drain();

    // random phases: idling mixes, one with a long receiver hold-off
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      random_transform(cfg);
      load_transform(cfg);
      for (int n = 0; n < 170; n++) begin
        if (p == 0 && n == 20) hold_req <= 1'b1;
        if (p == 0 && n == 21) hold_req <= 1'b0;
        // stretches with no idling at all
        if (n >= 120 && n < 140) begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        send_word(12'($urandom_range(4095)), 12'($urandom_range(4095)), 8'($urandom),
                  8'($urandom), 8'($urandom), 1'b0, 1'b0, 10'd0, 9'd0);
      end
      in_valid <= 1'b0;
      @(posedge clk);
      drain();
    end

    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
